@@ rtl/htpp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP host/port parser package
// Shared constants, codes, payload structs and character helpers.
// ----------------------------------------------------------------------------
package htpp_pkg;

  // Host buffer capacity per bank, and derived widths.
  localparam int HOST_CAP  = 64;
  localparam int IDX_W     = $clog2(HOST_CAP);
  localparam int WIDX_W    = IDX_W + 2;          // signed, holds -1 .. HOST_CAP
  localparam int RAM_DEPTH = 2 * HOST_CAP;       // two banks
  localparam int RAM_AW    = IDX_W + 1;

  localparam logic [15:0] DEFAULT_PORT_RST = 16'd80;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_H_LO   = 8'h68;
  localparam logic [7:0] CH_H_UP   = 8'h48;

  localparam int SCHEME_LEN = 4;
  localparam logic [7:0] SCHEME_TEXT [SCHEME_LEN] = '{8'h68, 8'h74, 8'h74, 8'h70};

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_START,
    PH_SCHEME,
    PH_COLON,
    PH_SLASH,
    PH_HOST,
    PH_PORT
  } phase_t;

  typedef enum logic [2:0] {
    CLS_ERR   = 3'd0,
    CLS_EMPTY = 3'd1,
    CLS_DOM   = 3'd2,
    CLS_DOMP  = 3'd3,
    CLS_V4    = 3'd4,
    CLS_V4P   = 3'd5,
    CLS_V6    = 3'd6,
    CLS_V6P   = 3'd7
  } class_t;

  // Host buffer write request
  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  // Finished string handed to the emitter
  typedef struct packed {
    logic        valid;
    logic        bank;
    class_t      cls;
    logic [15:0] port;
    logic        empty;
  } job_t;

  // Bank release: drop all valid bits of one bank
  typedef struct packed {
    logic en;
    logic bank;
  } vclr_t;

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  // acc * 10 + digit, modulo 2^16
  function automatic logic [15:0] port_step(logic [15:0] acc, logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    return (acc << 3) + (acc << 1) + {8'b0, d};
  endfunction

  // Closing verdict: an open IPv6 bracket or a full host is an error
  function automatic class_t finish_class(class_t cls, logic closed, logic full);
    class_t r;
    r = cls;
    if ((cls inside {CLS_V6, CLS_V6P}) && !closed) r = CLS_ERR;
    if (full) r = CLS_ERR;
    return r;
  endfunction

endpackage

@@ rtl/http_target_host_port_parser_unit.sv @@
`timescale 1ns / 1ps
// The first result of a run passes through the emitter's read stage and its output register.
// Throughput: one request byte per cycle in, one result per cycle out while out_ready is high;
// a run's host bytes go out in order, paced by the single read port of the host buffer RAM.
// An end-of-string byte waits while the previous run is still being read out.
// Reset (synchronous, active high) clears parse state, valid bits and the output stages;
// default_port returns to 80. No clearing pass is needed.
// ----------------------------------------------------------------------------
// HTTP request-target host/port parser
// Classifies the host part of a request target and emits the host bytes with
// the class and port.
// ----------------------------------------------------------------------------
module http_target_host_port_parser_unit
  import htpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  host_byte,
  output logic [2:0]  host_class,
  output logic [15:0] port_number,
  output logic        last,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  // The host buffer is split in two banks. The parser fills one bank while
  // the emitter drains the other, so a new request streams in during the
  // previous run. Per-entry valid bits (flops) mark stored host bytes; a bank
  // is released by dropping all its valid bits when its run is read out.

  logic                     take;
  logic                     emit_busy;
  ram_wr_t                  ram_wr;
  job_t                     job;
  vclr_t                    vclr;
  logic [1:0][HOST_CAP-1:0] valid_bits;
  logic                     rd_en;
  logic [RAM_AW-1:0]        rd_addr;
  logic [7:0]               rd_data;

  // Hold the end-of-string byte while the other bank is still going out;
  // ordinary bytes go into the free bank at full rate.
  assign in_ready = !(emit_busy && end_of_string);
  assign take     = in_valid && in_ready;

  htpp_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .in_byte      (in_byte),
    .end_of_string(end_of_string),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .vclr         (vclr),
    .wr           (ram_wr),
    .job          (job),
    .valid_bits   (valid_bits)
  );

  // Parser writes its bank, emitter reads the other: no same-entry overlap.
  htpp_host_ram u_ram (
    .clk    (clk),
    .wr     (ram_wr),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  htpp_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .job        (job),
    .valid_bits (valid_bits),
    .rd_data    (rd_data),
    .out_ready  (out_ready),
    .busy       (emit_busy),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .vclr       (vclr),
    .out_valid  (out_valid),
    .host_byte  (host_byte),
    .host_class (host_class),
    .port_number(port_number),
    .last       (last)
  );

endmodule

@@ rtl/htpp_host_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Host buffer RAM
// Two banks of host bytes, one write port, one registered read port.
// ----------------------------------------------------------------------------
module htpp_host_ram
  import htpp_pkg::*;
(
  input  logic              clk,
  input  ram_wr_t           wr,
  input  logic              rd_en,
  input  logic [RAM_AW-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [RAM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/htpp_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character parser
// Per-byte state machine; writes host bytes into the current bank and hands
// the bank to the emitter on the final byte of a string.
// ----------------------------------------------------------------------------
module htpp_parser
  import htpp_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [7:0]                    in_byte,
  input  logic                          end_of_string,
  input  logic                          cfg_we,
  input  logic [15:0]                   cfg_wdata,
  input  vclr_t                         vclr,
  output ram_wr_t                       wr,
  output job_t                          job,
  output logic [1:0][HOST_CAP-1:0]      valid_bits
);

  phase_t                   parse_phase, parse_phase_next;
  class_t                   class_so_far, class_so_far_next;
  logic [2:0]               scheme_cnt, scheme_cnt_next;
  logic [2:0]               dot_cnt, dot_cnt_next;
  logic                     v6_closed, v6_closed_next;
  logic                     scheme_seen, scheme_seen_next;
  logic [7:0]               prev_byte, prev_byte_next;
  logic signed [WIDX_W-1:0] widx, widx_next;
  logic [15:0]              port_acc, port_acc_next;
  logic                     verdict_done, verdict_done_next;
  logic [IDX_W:0]           spaces, spaces_next;
  logic                     pbank;
  logic [15:0]              default_port;
  logic [1:0][HOST_CAP-1:0] valid_next;

  logic                     wr_en;
  logic [IDX_W-1:0]         wr_idx;
  logic [HOST_CAP-1:0]      clr_mask;
  logic                     valid0_after;

  // Next state
  always_comb begin
    logic [7:0] c;
    logic       stop;
    phase_t     ph;

    parse_phase_next  = parse_phase;
    class_so_far_next = class_so_far;
    scheme_cnt_next   = scheme_cnt;
    dot_cnt_next      = dot_cnt;
    v6_closed_next    = v6_closed;
    scheme_seen_next  = scheme_seen;
    prev_byte_next    = prev_byte;
    widx_next         = widx;
    port_acc_next     = port_acc;
    verdict_done_next = verdict_done;
    spaces_next       = spaces;
    wr_en             = 1'b0;
    wr_idx            = '0;
    clr_mask          = '0;
    c                 = in_byte;
    stop              = 1'b0;
    ph                = parse_phase;

    if (take && !verdict_done) begin
      if (c == CH_NUL) begin
        class_so_far_next = finish_class(class_so_far, v6_closed, widx >= HOST_CAP);
        verdict_done_next = 1'b1;
      end else begin
        if (ph == PH_SKIP) begin
          if (c == CH_SPACE && spaces < HOST_CAP) begin
            spaces_next = spaces + 1'b1;
            stop        = 1'b1;
          end else begin
            ph               = PH_START;
            parse_phase_next = PH_START;
          end
        end

        // Port digits after the host
        if (!stop && ph == PH_PORT) begin
          stop = 1'b1;
          if (is_digit(c)) begin
            port_acc_next = port_step(port_acc, c);
          end else if (c == CH_SLASH) begin
            class_so_far_next = finish_class(class_so_far, v6_closed, widx >= HOST_CAP);
            verdict_done_next = 1'b1;
          end
        end

        if (!stop) begin
          case (ph)
            PH_START: begin
              if (c == CH_H_LO || c == CH_H_UP) begin
                class_so_far_next = CLS_DOM;
                parse_phase_next  = PH_SCHEME;
                scheme_cnt_next   = 3'd1;
              end else if (c == CH_SLASH) begin
                port_acc_next     = '0;
                verdict_done_next = 1'b1;
                stop              = 1'b1;
              end else if (c == CH_LBRACK) begin
                class_so_far_next = CLS_V6;
                parse_phase_next  = PH_HOST;
                widx_next         = '1;
              end else begin
                parse_phase_next  = PH_HOST;
                class_so_far_next = is_digit(c) ? CLS_V4 : CLS_DOM;
              end
            end
            PH_SCHEME: begin
              if (scheme_cnt >= 3'(SCHEME_LEN)) begin
                parse_phase_next = (c == CH_COLON) ? PH_COLON : PH_HOST;
              end
              if (scheme_cnt < 3'(SCHEME_LEN) && c == SCHEME_TEXT[scheme_cnt[1:0]]) begin
                scheme_cnt_next = scheme_cnt + 3'd1;
              end
            end
            PH_COLON: begin
              if (c == CH_SLASH) begin
                parse_phase_next = PH_SLASH;
              end else if (is_digit(c)) begin
                parse_phase_next = PH_PORT;
                port_acc_next    = port_step(port_acc, c);
                widx_next        = '1;
              end else begin
                class_so_far_next = CLS_ERR;
                port_acc_next     = '0;
                verdict_done_next = 1'b1;
                stop              = 1'b1;
              end
            end
            PH_SLASH: begin
              if (c == CH_SLASH && !scheme_seen) begin
                scheme_seen_next = 1'b1;
                parse_phase_next = PH_HOST;
                // drop what the scheme left in the buffer
                for (int l = 0; l < HOST_CAP; l++) begin
                  clr_mask[l] = (l <= int'(widx));
                end
                widx_next = '1;
              end else begin
                if (c == CH_SLASH) class_so_far_next = CLS_ERR;
                port_acc_next     = '0;
                verdict_done_next = 1'b1;
                stop              = 1'b1;
              end
            end
            default: begin
              // host characters
              if (c == CH_SLASH) begin
                if (prev_byte == CH_SLASH && scheme_seen) class_so_far_next = CLS_ERR;
                if ((class_so_far == CLS_V6 || class_so_far == CLS_V6P) && !v6_closed) begin
                  class_so_far_next = CLS_ERR;
                end
                port_acc_next     = '0;
                verdict_done_next = 1'b1;
                stop              = 1'b1;
              end else if (c != CH_COLON) begin
                case (class_so_far)
                  CLS_DOM: begin
                    if (c == CH_LBRACK) begin
                      class_so_far_next = CLS_V6;
                      widx_next         = '1;
                    end
                  end
                  CLS_V4: begin
                    if (!is_digit(c) && c != CH_DOT) begin
                      class_so_far_next = CLS_DOM;
                    end else if (c == CH_DOT) begin
                      dot_cnt_next = dot_cnt + 3'd1;
                      if (dot_cnt_next >= 3'd4) begin
                        class_so_far_next = CLS_ERR;
                        port_acc_next     = '0;
                        verdict_done_next = 1'b1;
                        stop              = 1'b1;
                      end
                    end
                  end
                  CLS_V6: begin
                    if (!is_digit(c) && c != CH_RBRACK) begin
                      class_so_far_next = CLS_DOM;
                    end else if (c == CH_RBRACK) begin
                      v6_closed_next = 1'b1;
                    end
                  end
                  default: begin
                    class_so_far_next = CLS_ERR;
                    port_acc_next     = '0;
                    verdict_done_next = 1'b1;
                    stop              = 1'b1;
                  end
                endcase
              end else if (class_so_far != CLS_V6) begin
                parse_phase_next = PH_COLON;
                if (class_so_far == CLS_V4) begin
                  class_so_far_next = CLS_V4P;
                end else if (class_so_far == CLS_DOM) begin
                  class_so_far_next = CLS_DOMP;
                  widx_next         = '1;
                end else begin
                  class_so_far_next = CLS_ERR;
                end
              end else if (v6_closed) begin
                parse_phase_next  = PH_COLON;
                class_so_far_next = CLS_V6P;
              end
            end
          endcase

          // store the byte and advance the write index
          if (!stop) begin
            if (widx_next >= 0 && widx_next < HOST_CAP && !v6_closed_next) begin
              wr_en  = 1'b1;
              wr_idx = widx_next[IDX_W-1:0];
            end
            widx_next      = widx_next + WIDX_W'(1);
            prev_byte_next = c;
            if (parse_phase_next == PH_PORT) begin
              if (!(valid_bits[pbank][0] || (wr_en && wr_idx == '0))) begin
                class_so_far_next = CLS_ERR;
                port_acc_next     = '0;
                verdict_done_next = 1'b1;
              end
            end else if (widx_next >= HOST_CAP) begin
              class_so_far_next = finish_class(class_so_far_next, v6_closed_next, 1'b1);
              verdict_done_next = 1'b1;
            end
          end
        end
      end
    end

    valid_next = valid_bits;
    if (vclr.en) valid_next[vclr.bank] = '0;
    valid_next[pbank] = valid_next[pbank] & ~clr_mask;
    if (wr_en) valid_next[pbank][wr_idx] = 1'b1;
  end

  // Outputs
  always_comb begin
    valid0_after = (valid_bits[pbank][0] & ~clr_mask[0]) | (wr_en && wr_idx == '0);

    wr.en   = wr_en;
    wr.addr = {pbank, wr_idx};
    wr.data = in_byte;

    job.valid = take && end_of_string;
    job.bank  = pbank;
    job.cls   = verdict_done_next ? class_so_far_next
              : finish_class(class_so_far_next, v6_closed_next, widx_next >= HOST_CAP);
    job.port  = (port_acc_next == '0) ? default_port : port_acc_next;
    job.empty = !valid0_after;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_port <= DEFAULT_PORT_RST;
      valid_bits   <= '0;
      pbank        <= 1'b0;
    end else begin
      if (cfg_we) default_port <= cfg_wdata;
      valid_bits <= valid_next;
      if (take && end_of_string) pbank <= ~pbank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && end_of_string)) begin
      parse_phase  <= PH_SKIP;
      class_so_far <= CLS_EMPTY;
      scheme_cnt   <= '0;
      dot_cnt      <= '0;
      v6_closed    <= 1'b0;
      scheme_seen  <= 1'b0;
      prev_byte    <= '0;
      widx         <= '0;
      port_acc     <= '0;
      verdict_done <= 1'b0;
      spaces       <= '0;
    end else begin
      parse_phase  <= parse_phase_next;
      class_so_far <= class_so_far_next;
      scheme_cnt   <= scheme_cnt_next;
      dot_cnt      <= dot_cnt_next;
      v6_closed    <= v6_closed_next;
      scheme_seen  <= scheme_seen_next;
      prev_byte    <= prev_byte_next;
      widx         <= widx_next;
      port_acc     <= port_acc_next;
      verdict_done <= verdict_done_next;
      spaces       <= spaces_next;
    end
  end

endmodule

@@ rtl/htpp_emitter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result emitter
// Reads one bank of the host buffer in order and sends the run of results.
// ----------------------------------------------------------------------------
module htpp_emitter
  import htpp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  job_t                     job,
  input  logic [1:0][HOST_CAP-1:0] valid_bits,
  input  logic [7:0]               rd_data,
  input  logic                     out_ready,
  output logic                     busy,
  output logic                     rd_en,
  output logic [RAM_AW-1:0]        rd_addr,
  output vclr_t                    vclr,
  output logic                     out_valid,
  output logic [7:0]               host_byte,
  output logic [2:0]               host_class,
  output logic [15:0]              port_number,
  output logic                     last
);

  logic             bank;
  class_t           cls;
  logic [15:0]      port;
  logic             empty;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] k_inc;

  logic             s1_valid;
  logic             s1_zero;
  logic             s1_last;
  class_t           s1_cls;
  logic [15:0]      s1_port;

  logic             s1_move;
  logic             issue;
  logic             run_end;

  always_comb begin
    k_inc   = k + 1'b1;
    run_end = empty || (k == IDX_W'(HOST_CAP - 1)) || !valid_bits[bank][k_inc];
    s1_move = s1_valid && (!out_valid || out_ready);
    issue   = busy && (!s1_valid || s1_move);
    rd_en   = issue && !empty;
    rd_addr = {bank, k};
    vclr.en   = issue && run_end;
    vclr.bank = bank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (job.valid) begin
        busy <= 1'b1;
      end else if (issue && run_end) begin
        busy <= 1'b0;
      end

      if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end

      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job.valid) begin
      bank  <= job.bank;
      cls   <= job.cls;
      port  <= job.port;
      empty <= job.empty;
      k     <= '0;
    end else if (issue) begin
      k <= k_inc;
    end

    if (issue) begin
      s1_zero <= empty;
      s1_last <= run_end;
      s1_cls  <= cls;
      s1_port <= port;
    end

    if (s1_move) begin
      host_byte   <= s1_zero ? 8'h00 : rd_data;
      host_class  <= s1_cls;
      port_number <= s1_port;
      last        <= s1_last;
    end
  end

endmodule
